>>> rtl/core/pcsp_pkg.sv
// ============================================================================
// pcsp_pkg: shared types and constants of the playback clock
// Request codes and fixed scale constants.
// ============================================================================
`default_nettype none
package pcsp_pkg;
    localparam logic [63:0] TIME_BASE    = 64'd1000000;
    localparam logic [63:0] SPEED_NORMAL = 64'd1000;
    localparam logic [31:0] FREQ_RESET   = 32'd1000000;

    typedef enum logic [2:0] {
        REQ_READ   = 3'd0,
        REQ_SPEED  = 3'd1,
        REQ_PAUSE  = 3'd2,
        REQ_RESUME = 3'd3,
        REQ_DISC   = 3'd4,
        REQ_FULL   = 3'd5,
        REQ_RSV6   = 3'd6,
        REQ_RSV7   = 3'd7
    } t_req;
endpackage
`default_nettype wire

>>> rtl/core/playback_clock_speed_pause_top.sv
// ============================================================================
// playback_clock_speed_pause_top: playback clock with speed and pause
// Keeps a microsecond clock derived from a reference tick count and handles
// read, speed, pause, resume and discontinuity requests.
// ============================================================================
// Passes: a request runs the clock pass, preceded by a restart when one is
// pending, by a discontinuity pass for a normal discontinuity (two passes) and
// by rate and start passes for a nonzero speed change (three passes).
// Each muldiv pass runs operand load, a 64x64 multiply in 32x32 partial
// products, a 128-step restoring divide and a finishing state.
// One request at a time; s_axis_tready is low from acceptance until the result
// is taken.
// Reset (synchronous, i_rst_n low) restores tick_frequency to 1000000 and
// arms the restart so the first request starts the clock.
`default_nettype none
module playback_clock_speed_pause_top import pcsp_pkg::*; (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_we,
    input  wire logic [31:0]  i_cfg_wdata,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // tdata: req_type[2:0], now_ticks[65:3], speed[82:66], pts_us[145:83],
    // delay_us[177:146], zero pad [183:178]
    input  wire logic [183:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // tdata: clock_us[63:0], distance_us[127:64]
    output logic [127:0]      m_axis_tdata
);
    typedef enum logic [2:0] {
        S_IDLE, S_PRE, S_POST, S_MUL, S_DIV, S_FIN, S_OUT
    } t_state;

    // which muldiv pass is running
    typedef enum logic [1:0] {P_RATE, P_START, P_DISC, P_CLOCK} t_pass;

    t_state r_state;
    t_pass  r_pass;
    logic [31:0] r_freq;
    logic [63:0] r_start, r_pause, r_rate, r_disc;
    logic        r_paused, r_pend;
    t_req        r_req;
    logic [63:0] r_now, r_pts, r_dly, r_spd;
    logic [63:0] r_newrate;

    // shared muldiv unit registers
    logic [63:0]  r_ma, r_mb, r_md;
    logic         r_neg, r_dzero;
    logic [127:0] r_prod;
    logic [1:0]   r_mcnt;
    logic [63:0]  r_rem, r_q;
    logic [6:0]   r_dcnt;
    logic [127:0] r_clkout;

    logic [63:0] n_a, n_b, n_d;
    logic [31:0] w_ph_a, w_ph_b;
    logic [63:0] w_pp;
    logic [64:0] w_rsh;
    logic        w_ge;
    logic [63:0] w_qres, w_ref, w_clk;

    function automatic logic [63:0] f_abs(input logic [63:0] v);
        f_abs = v[63] ? (64'd0 - v) : v;
    endfunction

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = r_clkout;

    // operand selection for the next pass
    always_comb begin
        unique case (r_pass)
            P_RATE: begin
                n_a = {32'd0, r_freq};
                n_b = SPEED_NORMAL;
                n_d = r_spd;
            end
            P_START: begin
                n_a = r_newrate;
                n_b = r_now - r_start;
                n_d = r_rate;
            end
            P_DISC: begin
                n_a = r_dly;
                n_b = r_rate;
                n_d = TIME_BASE;
            end
            P_CLOCK: begin
                n_a = TIME_BASE;
                n_b = w_ref - r_start;
                n_d = r_rate;
            end
        endcase
    end

    assign w_ref = r_paused ? r_pause : r_now;

    // one 32x32 partial product a cycle
    assign w_ph_a = r_mcnt[1] ? r_ma[63:32] : r_ma[31:0];
    assign w_ph_b = r_mcnt[0] ? r_mb[63:32] : r_mb[31:0];
    assign w_pp   = {32'd0, w_ph_a} * {32'd0, w_ph_b};

    assign w_rsh  = {r_rem, r_prod[127]};
    assign w_ge   = (w_rsh >= {1'b0, r_md});
    // zero divisor gives a zero quotient; the sign is applied to the magnitude
    assign w_qres = r_dzero ? 64'd0 : (r_neg ? (64'd0 - r_q) : r_q);
    assign w_clk  = w_qres + r_disc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_freq   <= FREQ_RESET;
            r_start  <= '0;
            r_pause  <= '0;
            r_paused <= 1'b0;
            r_rate   <= {32'd0, FREQ_RESET};
            r_disc   <= '0;
            r_pend   <= 1'b1;
            r_pass   <= P_CLOCK;
        end else begin
            if (i_cfg_we) begin
                r_freq <= i_cfg_wdata;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_req   <= t_req'(s_axis_tdata[2:0]);
                        r_now   <= {1'b0, s_axis_tdata[65:3]};
                        r_spd   <= {{47{s_axis_tdata[82]}}, s_axis_tdata[82:66]};
                        r_pts   <= {s_axis_tdata[145], s_axis_tdata[145:83]};
                        r_dly   <= {{32{s_axis_tdata[177]}}, s_axis_tdata[177:146]};
                        r_state <= S_PRE;
                    end
                end
                S_PRE: begin
                    // apply the request, pick the first pass
                    r_pass <= P_CLOCK;
                    unique case (r_req)
                        REQ_SPEED: begin
                            if (r_spd == 64'd0) begin
                                if (!r_paused) begin
                                    r_pause  <= r_now;
                                    r_paused <= 1'b1;
                                end
                            end else begin
                                r_pass <= P_RATE;
                                if (r_paused) begin
                                    r_start  <= r_start + (r_now - r_pause);
                                    r_paused <= 1'b0;
                                end
                            end
                        end
                        REQ_PAUSE: begin
                            if (!r_paused) begin
                                r_pause  <= r_now;
                                r_paused <= 1'b1;
                            end
                        end
                        REQ_RESUME: begin
                            if (r_paused) begin
                                r_start  <= r_start + (r_now - r_pause);
                                r_paused <= 1'b0;
                            end
                        end
                        REQ_DISC: r_pass <= P_DISC;
                        REQ_FULL: r_pend <= 1'b1;
                        default: ;
                    endcase
                    r_state <= S_POST;
                end
                S_POST: begin
                    // restart happens only before the clock pass; stay here while it is
                    // applied so the pass sees the restarted state
                    if (r_pass == P_CLOCK && r_pend) begin
                        r_start  <= r_now;
                        r_rate   <= {32'd0, r_freq};
                        r_paused <= 1'b0;
                        r_disc   <= '0;
                        r_pend   <= 1'b0;
                    end else begin
                        r_ma    <= f_abs(n_a);
                        r_mb    <= f_abs(n_b);
                        r_md    <= f_abs(n_d);
                        r_neg   <= n_a[63] ^ n_b[63] ^ n_d[63];
                        r_dzero <= (n_d == 64'd0);
                        r_prod  <= '0;
                        r_mcnt  <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    unique case (r_mcnt)
                        2'd0: r_prod <= r_prod + {64'd0, w_pp};
                        2'd1, 2'd2: r_prod <= r_prod + {32'd0, w_pp, 32'd0};
                        default: r_prod <= r_prod + {w_pp, 64'd0};
                    endcase
                    r_mcnt <= r_mcnt + 2'd1;
                    if (r_mcnt == 2'd3) begin
                        r_rem   <= '0;
                        r_q     <= '0;
                        r_dcnt  <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    // advance one quotient bit
                    r_prod <= {r_prod[126:0], 1'b0};
                    if (w_ge) begin
                        r_rem <= 64'(w_rsh - {1'b0, r_md});
                        r_q   <= {r_q[62:0], 1'b1};
                    end else begin
                        r_rem <= w_rsh[63:0];
                        r_q   <= {r_q[62:0], 1'b0};
                    end
                    r_dcnt <= r_dcnt + 7'd1;
                    if (r_dcnt == 7'd127) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    // consume the quotient and pick the next pass
                    unique case (r_pass)
                        P_RATE: begin
                            r_newrate <= w_qres;
                            r_pass    <= P_START;
                            r_state   <= S_POST;
                        end
                        P_START: begin
                            r_start <= r_now - w_qres;
                            r_rate  <= r_newrate;
                            r_pass  <= P_CLOCK;
                            r_state <= S_POST;
                        end
                        P_DISC: begin
                            r_start <= r_now + w_qres;
                            r_disc  <= r_pts;
                            r_pend  <= 1'b0;
                            r_pass  <= P_CLOCK;
                            r_state <= S_POST;
                        end
                        P_CLOCK: begin
                            r_clkout <= {w_qres, w_clk};
                            r_state  <= S_OUT;
                        end
                    endcase
                end
                S_OUT: begin
                    // hold the result until the sink takes it
                    if (m_axis_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> tb/playback_clock_speed_pause_top_test.sv
`timescale 1ns / 1ps
// ============================================================================
// playback_clock_speed_pause_top_test: self-checking bench of the playback clock
// Sends every request code over the input stream, predicts clock_us and
// distance_us for each one in a local model and compares every returned
// result in order, under random source and sink stalls but for the last stretch.
// ============================================================================
`default_nettype none
module playback_clock_speed_pause_top_test;
    import pcsp_pkg::*;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_we;
    logic [31:0]  i_cfg_wdata;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // tdata: req_type, now_ticks, speed, pts_us, delay_us, zero pad
    logic [183:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // tdata: clock_us, distance_us
    logic [127:0] m_axis_tdata;

    playback_clock_speed_pause_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock state mirror: tick rate register plus the playback state.
    logic [63:0] freq_q;
    logic [63:0] start_q;
    logic [63:0] pause_q;
    logic        paused_q;
    logic [63:0] rate_q;
    logic [63:0] offset_q;
    logic        restart_q;

    logic [127:0] clock_q[$];   // pending {distance, clock} pairs
    int           n_err;
    int           n_req;
    int           n_res;
    bit           stall_en;     // random idling on both sides
    logic [62:0]  now_q;        // running reference tick count

    // Signed a*b/d at 128 bits, truncated toward zero, low 64 bits kept.
    function automatic logic [63:0] scale_div(logic [63:0] a, logic [63:0] b,
                                              logic [63:0] d);
        logic [127:0] prod;
        logic [127:0] quo;
        logic [63:0]  ma, mb, md;
        logic         neg;
        if (d == 64'd0) return 64'd0;
        neg  = a[63] ^ b[63] ^ d[63];
        ma   = a[63] ? -a : a;
        mb   = b[63] ? -b : b;
        md   = d[63] ? -d : d;
        prod = {64'd0, ma} * {64'd0, mb};
        quo  = prod / {64'd0, md};
        return neg ? -quo[63:0] : quo[63:0];
    endfunction

    task automatic model_reset();
        freq_q    = {32'd0, FREQ_RESET};
        start_q   = '0;
        pause_q   = '0;
        paused_q  = 1'b0;
        rate_q    = {32'd0, FREQ_RESET};
        offset_q  = '0;
        restart_q = 1'b1;
    endtask

    // Advance the mirror by one request and queue its expected result.
    task automatic predict_clock(t_req req, logic [62:0] now_t, logic [16:0] spd,
                                 logic [62:0] pts, logic [31:0] dly);
        logic [63:0] now64, spd64, newrate, refv, clk;
        now64 = {1'b0, now_t};
        spd64 = {{47{spd[16]}}, spd};
        case (req)
            REQ_SPEED: begin
                if (spd64 == 64'd0) begin
                    if (!paused_q) begin
                        pause_q  = now64;
                        paused_q = 1'b1;
                    end
                end else begin
                    newrate = scale_div(freq_q, SPEED_NORMAL, spd64);
                    if (paused_q) begin
                        start_q  = start_q + (now64 - pause_q);
                        paused_q = 1'b0;
                    end
                    start_q = now64 - scale_div(newrate, now64 - start_q, rate_q);
                    rate_q  = newrate;
                end
            end
            REQ_PAUSE: begin
                if (!paused_q) begin
                    pause_q  = now64;
                    paused_q = 1'b1;
                end
            end
            REQ_RESUME: begin
                if (paused_q) begin
                    start_q  = start_q + (now64 - pause_q);
                    paused_q = 1'b0;
                end
            end
            REQ_DISC: begin
                start_q   = now64 + scale_div({{32{dly[31]}}, dly}, rate_q, TIME_BASE);
                offset_q  = {pts[62], pts};
                restart_q = 1'b0;
            end
            REQ_FULL: restart_q = 1'b1;
            default: ;
        endcase
        if (restart_q) begin
            start_q   = now64;
            rate_q    = freq_q;
            paused_q  = 1'b0;
            offset_q  = '0;
            restart_q = 1'b0;
        end
        refv = paused_q ? pause_q : now64;
        clk  = scale_div(TIME_BASE, refv - start_q, rate_q) + offset_q;
        clock_q.push_back({clk - offset_q, clk});
    endtask

    always #2 i_clk = ~i_clk;

    // Idle for a random gap, then hold valid until the handshake and drop it after.
    // Inputs change at the falling edge; ready is stable there.
    task automatic send_request(t_req req, logic [62:0] now_t, logic [16:0] spd,
                                logic [62:0] pts, logic [31:0] dly);
        if (stall_en && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        predict_clock(req, now_t, spd, pts, dly);
        s_axis_tdata  = {6'd0, dly, pts, spd, now_t, req};
        s_axis_tvalid = 1'b1;
        while (!s_axis_tready) @(negedge i_clk);
        @(posedge i_clk);
        n_req++;
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    // Let the block drain, then pause for any trailing work.
    task automatic wait_idle();
        while (clock_q.size() != 0) @(negedge i_clk);
        repeat (600) @(negedge i_clk);
    endtask

    task automatic write_freq(logic [31:0] f);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= f;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        freq_q = {32'd0, f};
    endtask

    function automatic logic [16:0] rand_speed();
        case ($urandom_range(0, 5))
            0: return 17'd1000;
            1: return 17'd0;
            2: return -17'sd1000;
            3: return 17'($signed($urandom_range(0, 128000)) - 64000);
            4: return 17'($urandom);
            default: return 17'($signed($urandom_range(0, 8000)) - 4000);
        endcase
    endfunction

    function automatic logic [62:0] rand_wide();
        return 63'({$urandom, $urandom});
    endfunction

    // Advance the tick counter, mostly forward by small steps.
    function automatic logic [62:0] next_now();
        case ($urandom_range(0, 9))
            0: now_q = rand_wide();
            1: now_q = now_q;
            default: now_q = now_q + 63'($urandom_range(1, 5000000));
        endcase
        return now_q;
    endfunction

    // Sink side: stall ready at random and check each result against the queue.
    always @(negedge i_clk) begin
        if (stall_en && $urandom_range(0, 7) == 0)
            m_axis_tready <= 1'b0;
        else if (!stall_en || $urandom_range(0, 5) != 0)
            m_axis_tready <= 1'b1;
    end

    always @(posedge i_clk) begin
        logic [127:0] want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_res++;
            if (clock_q.size() == 0) begin
                $error("result with no request pending: %h", m_axis_tdata);
                n_err++;
            end else begin
                want = clock_q.pop_front();
                if (m_axis_tdata[63:0] !== want[63:0]) begin
                    $error("clock_us expected %0d got %0d",
                           $signed(want[63:0]), $signed(m_axis_tdata[63:0]));
                    n_err++;
                end
                if (m_axis_tdata[127:64] !== want[127:64]) begin
                    $error("distance_us expected %0d got %0d",
                           $signed(want[127:64]), $signed(m_axis_tdata[127:64]));
                    n_err++;
                end
            end
        end
    end

    // Every request code after reset, several at the field extremes.
    task automatic test_directed();
        send_request(REQ_READ, 63'd100, 17'd0, 63'd0, 32'd0);
        send_request(REQ_READ, 63'd2000100, 17'd0, 63'd0, 32'd0);
        send_request(REQ_PAUSE, 63'd3000000, 17'd0, 63'd0, 32'd0);
        send_request(REQ_PAUSE, 63'd4000000, 17'd0, 63'd0, 32'd0);
        send_request(REQ_RESUME, 63'd5000000, 17'd0, 63'd0, 32'd0);
        send_request(REQ_RESUME, 63'd5000001, 17'd0, 63'd0, 32'd0);
        send_request(REQ_SPEED, 63'd6000000, 17'd2000, 63'd0, 32'd0);
        send_request(REQ_SPEED, 63'd7000000, -17'sd64000, 63'd0, 32'd0);
        send_request(REQ_SPEED, 63'd8000000, 17'd64000, 63'd0, 32'd0);
        send_request(REQ_SPEED, 63'd9000000, 17'd0, 63'd0, 32'd0);   // zero pauses
        send_request(REQ_SPEED, 63'd9500000, 17'd1000, 63'd0, 32'd0); // unpause
        send_request(REQ_SPEED, 63'd9600000, 17'h0ffff, 63'd0, 32'd0); // out of range
        send_request(REQ_SPEED, 63'd9700000, 17'h10000, 63'd0, 32'd0);
        send_request(REQ_DISC, 63'd10000000, 17'd0, {1'b0, {62{1'b1}}}, 32'h7fffffff);
        send_request(REQ_DISC, 63'd11000000, 17'd0, {1'b1, 62'd0}, 32'h80000000);
        send_request(REQ_DISC, {63{1'b1}}, 17'h1ffff, {63{1'b1}}, 32'hffffffff);
        send_request(REQ_READ, '0, 17'd0, 63'd0, 32'd0);
        send_request(REQ_FULL, 63'd12000000, 17'd0, 63'd0, 32'd0);
        send_request(REQ_RSV6, 63'd13000000, 17'd0, 63'd0, 32'd0); // reserved code, reads only
        send_request(REQ_RSV7, 63'd14000000, 17'd0, 63'd0, 32'd0);
        now_q = 63'd14000000;
    endtask

    // Random requests, mostly well-formed play sequences at one tick rate.
    task automatic test_random(int count);
        t_req req;
        for (int k = 0; k < count; k++) begin
            case ($urandom_range(0, 15))
                0, 1, 2, 3: req = REQ_READ;
                4, 5, 6:    req = REQ_SPEED;
                7, 8:       req = REQ_PAUSE;
                9, 10:      req = REQ_RESUME;
                11, 12:     req = REQ_DISC;
                13:         req = REQ_FULL;
                14:         req = REQ_RSV6;
                default:    req = REQ_RSV7;
            endcase
            send_request(req, next_now(), rand_speed(),
                         ($urandom_range(0, 3) == 0) ? rand_wide()
                             : 63'($signed($urandom_range(0, 2000000000))),
                         ($urandom_range(0, 3) == 0) ? $urandom
                             : 32'($signed($urandom_range(0, 2000000)) - 1000000));
        end
    endtask

    initial begin
        int phase_n;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b1;
        stall_en = 1'b1;
        n_err = 0;
        n_req = 0;
        n_res = 0;
        now_q = '0;
        model_reset();
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_random(300);
        // Sweep the tick rate, extremes included; zero exercises the zero divisor.
        write_freq(32'd1);
        test_random(150);
        write_freq(32'hffffffff);
        test_random(300);
        write_freq(32'd0);
        test_random(100);
        write_freq(32'd48000);
        test_random(300);
        write_freq($urandom);
        test_random(300);
        write_freq(32'd90000);
        stall_en = 1'b0;    // last stretch runs without idling
        test_random(400);

        while (clock_q.size() != 0) @(negedge i_clk);
        repeat (600) @(negedge i_clk);
        phase_n = 7;
        $display("covered %0d requests, %0d results over %0d tick-rate settings",
                 n_req, n_res, phase_n);
        if (n_err == 0 && clock_q.size() == 0)
            $display("playback_clock_speed_pause_top_test: clean");
        else
            $display("playback_clock_speed_pause_top_test: errors");
        $finish;
    end

    // The whole run, stalls included, should end well before this timeout.
    initial begin
        #40000000;
        $display("playback_clock_speed_pause_top_test: errors");
        $finish;
    end
endmodule
`default_nettype wire

>>> playback_clock_speed_pause_top.f
rtl/core/pcsp_pkg.sv
rtl/core/playback_clock_speed_pause_top.sv
tb/playback_clock_speed_pause_top_test.sv
